@@ rtl/core/lle_pkg.sv @@
// ----------------------------------------------------------------------------
// lle_pkg
// Types and constants shared by the list level expander.
// ----------------------------------------------------------------------------
package lle_pkg;

    localparam int MAX_LIST_LEN = 64;
    localparam int CNT_W        = $clog2(MAX_LIST_LEN + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARENT_MAX_DEF = 2'd0,
        CFG_PARENT_MAX_REP = 2'd1,
        CFG_ANCESTOR_DEF   = 2'd2,
        CFG_LIST_OPTIONAL  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] parent_max_def;
        logic [7:0] parent_max_rep;
        logic [7:0] ancestor_def;
        logic       list_optional;
    } t_cfg;

    // One classified input: the levels of its results and how many there are.
    typedef struct packed {
        logic [7:0]       out_def;
        logic [7:0]       rep_first;
        logic [7:0]       rep_later;
        logic             slot_used;
        logic [CNT_W-1:0] count;
    } t_cmd;

endpackage

@@ rtl/core/lle_if.sv @@
// ----------------------------------------------------------------------------
// lle_in_if / lle_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface lle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_def;
    logic [7:0] in_rep;
    logic       slot_null;
    logic [6:0] slot_size;

    modport source (output valid, in_def, in_rep, slot_null, slot_size, input ready);
    modport sink   (input valid, in_def, in_rep, slot_null, slot_size, output ready);
endinterface

interface lle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_def;
    logic [7:0] out_rep;
    logic       slot_used;
    logic       last;

    modport source (output valid, out_def, out_rep, slot_used, last, input ready);
    modport sink   (input valid, out_def, out_rep, slot_used, last, output ready);
endinterface

@@ rtl/core/lle_front.sv @@
// ----------------------------------------------------------------------------
// lle_front
// Holds the configuration and classifies each input beat into a command.
// ----------------------------------------------------------------------------
module lle_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                   i_in_def,
    input  logic [7:0]                   i_in_rep,
    input  logic                         i_slot_null,
    input  logic [6:0]                   i_slot_size,
    output lle_pkg::t_cmd                o_cmd
);
    import lle_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic [8:0] empty_def;
    logic [9:0] list_def;
    logic [8:0] later_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PARENT_MAX_DEF: n_cfg.parent_max_def = i_cfg_data[7:0];
                CFG_PARENT_MAX_REP: n_cfg.parent_max_rep = i_cfg_data[7:0];
                CFG_ANCESTOR_DEF:   n_cfg.ancestor_def   = i_cfg_data[7:0];
                CFG_LIST_OPTIONAL:  n_cfg.list_optional  = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Levels saturate at 255.
    assign empty_def = {1'b0, i_in_def} + 9'(r_cfg.list_optional);
    assign list_def  = 10'(r_cfg.parent_max_def) + 10'(r_cfg.list_optional) + 10'd1;
    assign later_rep = {1'b0, r_cfg.parent_max_rep} + 9'd1;

    always_comb begin
        o_cmd.out_def   = i_in_def;
        o_cmd.rep_first = i_in_rep;
        o_cmd.rep_later = i_in_rep;
        o_cmd.slot_used = 1'b1;
        o_cmd.count     = CNT_W'(1);
        if (i_in_def < r_cfg.ancestor_def) begin
            o_cmd.slot_used = 1'b0;
        end else if (i_in_def < r_cfg.parent_max_def || i_slot_null) begin
            o_cmd.slot_used = 1'b1;
        end else if (i_slot_size == 7'd0) begin
            o_cmd.out_def = empty_def[8] ? 8'hFF : empty_def[7:0];
        end else begin
            o_cmd.out_def   = (list_def > 10'd255) ? 8'hFF : list_def[7:0];
            o_cmd.rep_later = later_rep[8] ? 8'hFF : later_rep[7:0];
            if (32'(i_slot_size) > MAX_LIST_LEN) begin
                o_cmd.count = CNT_W'(MAX_LIST_LEN);
            end else begin
                o_cmd.count = CNT_W'(i_slot_size);
            end
        end
    end

endmodule

@@ rtl/core/lle_queue.sv @@
// ----------------------------------------------------------------------------
// lle_queue
// Short command queue decoupling the classifier from the expander.
// ----------------------------------------------------------------------------
module lle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_pop,
    input  lle_pkg::t_cmd i_cmd,
    output lle_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import lle_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_fill;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/lle_back.sv @@
// ----------------------------------------------------------------------------
// lle_back
// Takes commands from the queue and emits one result beat per cycle unless o_out stalls.
// ----------------------------------------------------------------------------
module lle_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lle_pkg::t_cmd    i_cmd,
    input  logic             i_q_empty,
    output logic             o_pop,
    lle_out_if.source        o_out
);
    import lle_pkg::*;

    logic             r_busy;
    logic             r_first;
    logic [CNT_W-1:0] r_remain;
    t_cmd             r_cmd;
    logic             n_busy;
    logic             n_first;
    logic [CNT_W-1:0] n_remain;
    t_cmd             n_cmd;
    logic             beat;
    logic             final_beat;

    assign beat       = r_busy && o_out.ready;
    assign final_beat = (r_remain == CNT_W'(1));
    assign o_pop      = !i_q_empty && (!r_busy || (beat && final_beat));

    assign o_out.valid     = r_busy;
    assign o_out.out_def   = r_cmd.out_def;
    assign o_out.out_rep   = r_first ? r_cmd.rep_first : r_cmd.rep_later;
    assign o_out.slot_used = r_cmd.slot_used;
    assign o_out.last      = final_beat;

    always_comb begin
        n_busy   = r_busy;
        n_first  = r_first;
        n_remain = r_remain;
        n_cmd    = r_cmd;
        if (o_pop) begin
            n_busy   = 1'b1;
            n_first  = 1'b1;
            n_remain = i_cmd.count;
            n_cmd    = i_cmd;
        end else if (beat) begin
            n_first  = 1'b0;
            n_remain = r_remain - CNT_W'(1);
            if (final_beat) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_first  <= 1'b0;
            r_remain <= '0;
        end else begin
            r_busy   <= n_busy;
            r_first  <= n_first;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

@@ rtl/core/list_level_expander.sv @@
// ----------------------------------------------------------------------------
// list_level_expander
// Expands one nesting step of repetition and definition levels for a list
// column: each parent level pair becomes one or more child level pairs.
//
//   channel  dir  handshake        payload
//   i_in     in   valid/ready      in_def, in_rep, slot_null, slot_size
//   o_out    out  valid/ready      out_def, out_rep, slot_used, last
//   i_cfg_*  in   write enable     register index, write data
//
// The expander emits one result beat per cycle while o_out is ready; an input
// with a list of n > 0 elements gives n beats, at most 64, all others one. Its
// run counter sets that figure. A four-entry command queue lets the classifier
// keep accepting beats while the output stalls. Reset empties the queue and the
// expander and clears the registers to zero.
// ----------------------------------------------------------------------------
module list_level_expander (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lle_in_if.sink                         i_in,
    lle_out_if.source                      o_out
);
    import lle_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign i_in.ready = !q_full;
    assign q_push     = i_in.valid;

    lle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_def    (i_in.in_def),
        .i_in_rep    (i_in.in_rep),
        .i_slot_null (i_in.slot_null),
        .i_slot_size (i_in.slot_size),
        .o_cmd       (front_cmd)
    );

    lle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .i_cmd   (front_cmd),
        .o_cmd   (queue_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (queue_cmd),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

@@ rtl/core/lle_checker.sv @@
// ----------------------------------------------------------------------------
// lle_checker
// Port-level checks on the result channel of the list level expander.
// ----------------------------------------------------------------------------
module lle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_def,
    input logic [7:0] i_out_rep,
    input logic       i_out_slot_used,
    input logic       i_out_last
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_def)
            && $stable(i_out_rep) && $stable(i_out_slot_used) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Only list runs give more than one beat, and they always use the slot.
    a_run_uses_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_slot_used)
        else $error("non-final beat without slot use");

    // The rest of a run is held inside the expander, so it follows at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a run of result beats");

endmodule

bind list_level_expander lle_checker u_lle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_def       (o_out.out_def),
    .i_out_rep       (o_out.out_rep),
    .i_out_slot_used (o_out.slot_used),
    .i_out_last      (o_out.last)
);

@@ bench/list_level_expander_tb.sv @@
// ----------------------------------------------------------------------------
// list_level_expander_tb
// Drives parent level pairs with list slot flags into the list level expander
// under several register settings and random idling on both channels. Every result
// beat is checked against a predictor of the expansion rules or a typed level.
// ----------------------------------------------------------------------------
module list_level_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lle_pkg::*;

    localparam int IDLE_LIMIT  = 200;
    localparam int N_ROWS      = 22;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 35;

    typedef struct packed {
        logic [7:0] in_def;
        logic [7:0] in_rep;
        logic       slot_null;
        logic [6:0] slot_size;
    } t_item;

    typedef struct packed {
        logic [7:0] out_def;
        logic [7:0] out_rep;
        logic       slot_used;
        logic       last;
    } t_level;

    // A level typed into the table takes the place of the predicted one.
    typedef struct packed {
        logic   known;
        t_level lvl;
    } t_hint;

    typedef struct packed {
        logic [1:0] setting;
        logic [7:0] in_def;
        logic [7:0] in_rep;
        logic       slot_null;
        logic [6:0] slot_size;
        logic       known;
        logic [7:0] exp_def;
        logic [7:0] exp_rep;
        logic       exp_used;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lle_in_if  in_if ();
    lle_out_if out_if ();

    list_level_expander dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_cfg   cfg_now;
    t_level levels_expected[$];
    t_hint  hint_q[$];
    int     levels_due;
    int     idle_cycles;
    int     fail_count;
    int     items_taken;
    int     beats_checked;
    int     longest_run;
    int     settings_used;
    bit     calm_mode;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clip8(input int v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic int idle_gap();
        return calm_mode ? 0 : $urandom_range(0, 19);
    endfunction

    // Pushes the child levels that one parent position expands into.
    function automatic void expand_list_slot(input t_item it);
        int n;
        logic [7:0] child_def;
        logic [7:0] child_rep;
        if (it.in_def < cfg_now.ancestor_def) begin
            levels_expected.push_back('{it.in_def, it.in_rep, 1'b0, 1'b1});
        end else if (it.in_def < cfg_now.parent_max_def || it.slot_null) begin
            levels_expected.push_back('{it.in_def, it.in_rep, 1'b1, 1'b1});
        end else if (it.slot_size == 0) begin
            levels_expected.push_back('{clip8(int'(it.in_def) + cfg_now.list_optional),
                                        it.in_rep, 1'b1, 1'b1});
        end else begin
            n = (it.slot_size > MAX_LIST_LEN) ? MAX_LIST_LEN : int'(it.slot_size);
            child_def = clip8(int'(cfg_now.parent_max_def) + cfg_now.list_optional + 1);
            child_rep = clip8(int'(cfg_now.parent_max_rep) + 1);
            for (int k = 0; k < n; k++) begin
                levels_expected.push_back('{child_def, (k == 0) ? it.in_rep : child_rep,
                                            1'b1, (k == n - 1)});
            end
            if (n > longest_run) begin
                longest_run = n;
            end
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_hint  hint;
        t_level got;
        t_level want;
        bit     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_if.valid && in_if.ready) begin
                moved = 1'b1;
                items_taken++;
                hint = (hint_q.size() != 0) ? hint_q.pop_front() : '0;
                if (hint.known) begin
                    levels_expected.push_back(hint.lvl);
                end else begin
                    expand_list_slot('{in_if.in_def, in_if.in_rep, in_if.slot_null,
                                       in_if.slot_size});
                end
            end
            if (out_if.valid && out_if.ready) begin
                moved = 1'b1;
                beats_checked++;
                got = '{out_if.out_def, out_if.out_rep, out_if.slot_used, out_if.last};
                if (levels_expected.size() == 0) begin
                    note_failure($sformatf("ERROR: unexpected beat def %0d rep %0d used %0b last %0b",
                                           got.out_def, got.out_rep, got.slot_used, got.last));
                end else begin
                    want = levels_expected.pop_front();
                    if (got !== want) begin
                        note_failure($sformatf({"ERROR: beat %0d: expected def %0d rep %0d ",
                                                "used %0b last %0b, got def %0d rep %0d ",
                                                "used %0b last %0b"}, beats_checked,
                                               want.out_def, want.out_rep, want.slot_used,
                                               want.last, got.out_def, got.out_rep,
                                               got.slot_used, got.last));
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            levels_due  <= levels_expected.size();
        end
    end

    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("ERROR: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : result_sink
        int gap;
        out_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    task automatic send_item(input t_item it, input t_hint hint);
        int gap;
        gap = idle_gap();
        hint_q.push_back(hint);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.in_def    <= it.in_def;
        in_if.in_rep    <= it.in_rep;
        in_if.slot_null <= it.slot_null;
        in_if.slot_size <= it.slot_size;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    // Holds the input back until every outstanding result beat has arrived.
    task automatic drain_levels();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (levels_due != 0);
    endtask

    task automatic apply_setting(input t_cfg s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PARENT_MAX_DEF;
        i_cfg_data <= s.parent_max_def;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PARENT_MAX_REP;
        i_cfg_data <= s.parent_max_rep;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ANCESTOR_DEF;
        i_cfg_data <= s.ancestor_def;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIST_OPTIONAL;
        i_cfg_data <= {7'd0, s.list_optional};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_now = s;
        settings_used++;
    endtask

    function automatic t_cfg pick_setting(input int phase);
        t_cfg s;
        case (phase)
            0: s = '0;
            1: s = '{8'd253, 8'd254, 8'd253, 1'b1};
            6: s = '{8'd0, 8'd254, 8'd0, 1'b1};
            default: begin
                s.parent_max_def = $urandom_range(0, 253);
                s.parent_max_rep = $urandom_range(0, 254);
                s.ancestor_def   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 253)
                                                               : $urandom_range(0, s.parent_max_def);
                s.list_optional  = $urandom_range(0, 1);
            end
        endcase
        return s;
    endfunction

    // Mostly well-formed lists with short runs; the rest covers the null and
    // empty paths, defs below the parent maximum or the ancestor, and plain noise.
    function automatic t_item make_item();
        t_item it;
        int lo;
        int pick;
        int s;
        lo = (cfg_now.ancestor_def > cfg_now.parent_max_def) ? cfg_now.ancestor_def
                                                             : cfg_now.parent_max_def;
        it.in_rep    = $urandom_range(0, 255);
        it.in_def    = $urandom_range(lo, 255);
        it.slot_null = 1'b0;
        it.slot_size = 7'd0;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            s = $urandom_range(0, 19);
            if (s < 14) begin
                it.slot_size = $urandom_range(1, 8);
            end else if (s < 18) begin
                it.slot_size = $urandom_range(9, 64);
            end else begin
                it.slot_size = $urandom_range(65, 127);
            end
        end else if (pick < 68) begin
            it.slot_size = 7'd0;
        end else if (pick < 76) begin
            it.in_def    = $urandom_range(cfg_now.ancestor_def, 255);
            it.slot_null = 1'b1;
            it.slot_size = $urandom_range(0, 127);
        end else if (pick < 84 && cfg_now.parent_max_def > cfg_now.ancestor_def) begin
            it.in_def    = $urandom_range(cfg_now.ancestor_def, cfg_now.parent_max_def - 1);
            it.slot_null = $urandom_range(0, 1);
            it.slot_size = $urandom_range(0, 127);
        end else if (pick < 92 && cfg_now.ancestor_def > 0) begin
            it.in_def    = $urandom_range(0, cfg_now.ancestor_def - 1);
            it.slot_null = $urandom_range(0, 1);
            it.slot_size = $urandom_range(0, 127);
        end else begin
            it.in_def    = $urandom_range(0, 255);
            it.slot_null = $urandom_range(0, 1);
            it.slot_size = $urandom_range(0, 127);
        end
        return it;
    endfunction

    initial begin : stimulus
        t_row  directed_rows [N_ROWS];
        t_cfg  fixed_settings [4];
        t_row  row;
        t_hint hint;
        int    cur;

        fixed_settings = '{'0,
                           '{8'd3, 8'd2, 8'd2, 1'b1},
                           '{8'd253, 8'd254, 8'd253, 1'b1},
                           '{8'd253, 8'd254, 8'd0, 1'b0}};

        // setting, def, rep, null, size, typed, def, rep, used
        directed_rows = '{
            '{2'd0, 8'd0,   8'd0,   1'b0, 7'd0,   1'b1, 8'd0,   8'd0,   1'b1},
            '{2'd0, 8'd255, 8'd255, 1'b1, 7'd127, 1'b1, 8'd255, 8'd255, 1'b1},
            '{2'd0, 8'd7,   8'd3,   1'b0, 7'd1,   1'b1, 8'd1,   8'd3,   1'b1},
            '{2'd0, 8'd9,   8'd5,   1'b0, 7'd3,   1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd1, 8'd1,   8'd1,   1'b1, 7'd127, 1'b1, 8'd1,   8'd1,   1'b0},
            '{2'd1, 8'd0,   8'd255, 1'b0, 7'd64,  1'b1, 8'd0,   8'd255, 1'b0},
            '{2'd1, 8'd2,   8'd0,   1'b0, 7'd5,   1'b1, 8'd2,   8'd0,   1'b1},
            '{2'd1, 8'd3,   8'd1,   1'b1, 7'd0,   1'b1, 8'd3,   8'd1,   1'b1},
            '{2'd1, 8'd3,   8'd0,   1'b0, 7'd0,   1'b1, 8'd4,   8'd0,   1'b1},
            '{2'd1, 8'd255, 8'd200, 1'b0, 7'd0,   1'b1, 8'd255, 8'd200, 1'b1},
            '{2'd1, 8'd4,   8'd1,   1'b0, 7'd2,   1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd1, 8'd3,   8'd0,   1'b0, 7'd64,  1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd1, 8'd10,  8'd2,   1'b0, 7'd65,  1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd1, 8'd10,  8'd2,   1'b0, 7'd127, 1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd2, 8'd252, 8'd0,   1'b0, 7'd10,  1'b1, 8'd252, 8'd0,   1'b0},
            '{2'd2, 8'd253, 8'd254, 1'b0, 7'd0,   1'b1, 8'd254, 8'd254, 1'b1},
            '{2'd2, 8'd253, 8'd255, 1'b0, 7'd3,   1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd2, 8'd255, 8'd255, 1'b1, 7'd9,   1'b1, 8'd255, 8'd255, 1'b1},
            '{2'd2, 8'd255, 8'd0,   1'b0, 7'd1,   1'b0, 8'd0,   8'd0,   1'b0},
            '{2'd3, 8'd0,   8'd0,   1'b0, 7'd5,   1'b1, 8'd0,   8'd0,   1'b1},
            '{2'd3, 8'd253, 8'd7,   1'b0, 7'd0,   1'b1, 8'd253, 8'd7,   1'b1},
            '{2'd3, 8'd254, 8'd1,   1'b0, 7'd2,   1'b0, 8'd0,   8'd0,   1'b0}};

        cfg_now       = '0;
        fail_count    = 0;
        items_taken   = 0;
        beats_checked = 0;
        longest_run   = 0;
        settings_used = 0;
        calm_mode     = 1'b0;
        cur           = 0;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_PARENT_MAX_DEF;
        i_cfg_data      <= '0;
        in_if.valid     <= 1'b0;
        in_if.in_def    <= '0;
        in_if.in_rep    <= '0;
        in_if.slot_null <= 1'b0;
        in_if.slot_size <= '0;
        idle_cycles     <= 0;
        levels_due      <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first rows run on the register values left by reset.
        for (int k = 0; k < N_ROWS; k++) begin
            row = directed_rows[k];
            if (row.setting != cur) begin
                drain_levels();
                repeat (4) @(posedge i_clk);
                apply_setting(fixed_settings[row.setting]);
                cur = row.setting;
            end
            hint.known = row.known;
            hint.lvl   = '{row.exp_def, row.exp_rep, row.exp_used, 1'b1};
            send_item('{row.in_def, row.in_rep, row.slot_null, row.slot_size}, hint);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_levels();
            repeat (4) @(posedge i_clk);
            apply_setting(pick_setting(phase));
            calm_mode = (phase % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 3 && k == 17) begin
                    drain_levels();
                end
                send_item(make_item(), '0);
            end
        end

        drain_levels();
        repeat (16) @(posedge i_clk);
        if (levels_expected.size() != 0) begin
            note_failure($sformatf("ERROR: %0d result beats never arrived",
                                   levels_expected.size()));
        end

        $display("Covered %0d parent positions over %0d register settings, %0d beats checked.",
                 items_taken, settings_used, beats_checked);
        $display("Longest list run %0d, failures %0d.", longest_run, fail_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lle_pkg.sv
rtl/core/lle_if.sv
rtl/core/lle_front.sv
rtl/core/lle_queue.sv
rtl/core/lle_back.sv
rtl/core/list_level_expander.sv
rtl/core/lle_checker.sv
bench/list_level_expander_tb.sv
